// ===== hw/rtl/tgd_pkg.sv =====
// Package for the touch gesture detector.
// Holds the event codes, the register indexes and the controller/datapath types.
// No dependencies.
package tgd_pkg;

	typedef enum logic [2:0] {
		EV_UP          = 3'd0,
		EV_DOWN        = 3'd1,
		EV_HOLD        = 3'd2,
		EV_SWIPE_LEFT  = 3'd3,
		EV_SWIPE_RIGHT = 3'd4,
		EV_SWIPE_UP    = 3'd5,
		EV_SWIPE_DOWN  = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		REG_RAW_X_MIN    = 3'd0,
		REG_RAW_X_MAX    = 3'd1,
		REG_RAW_Y_MIN    = 3'd2,
		REG_RAW_Y_MAX    = 3'd3,
		REG_SCREEN_X_MAX = 3'd4,
		REG_SCREEN_Y_MAX = 3'd5,
		REG_SWIPE_DIST   = 3'd6,
		REG_SWIPE_TMAX   = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP_X,
		S_DIV_X,
		S_SETUP_Y,
		S_DIV_Y,
		S_GROUP,
		S_AVG,
		S_PRESS,
		S_RELEASE,
		S_EMIT
	} state_t;

	// dividend width of the range mapping: 12-bit offset times 12-bit screen max
	localparam int DIV_STEPS = 24;

	typedef struct packed {
		logic in_load;
		logic map_setup;
		logic map_sel;     // 0: screen x from raw y, 1: screen y from raw x
		logic div_step;
		logic acc_x;
		logic grp_upd;
		logic avg_step;
		logic press;
		logic release_upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic touched;
		logic div_last;
		logic grp_full;
		logic avg_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/touch_gesture_detector.sv =====
// Touch gesture detector top level: controller plus datapath.
// Depends on tgd_pkg, tgd_ctrl and tgd_dp.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | touched, raw_x, raw_y, raw_pressure, now_ms
//  out     | output    | out_valid/out_stall | event_kind, screen_x, screen_y, pressure,
//          |           |                     | position_valid
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample at a time. A touched sample runs two 24-step serial divides for the
// coordinate mappings and, when it completes a group, 3 reciprocal multiplies,
// the event update and the emit. A release runs the event update and the emit.
// Reset clears all gesture and group state. A stalled result holds in the output
// register; the next sample is still taken and waits only at its own emit step.
module touch_gesture_detector import tgd_pkg::*; #(
	parameter int SAMPLES           = 4,
	parameter int SWIPE_TIME_MIN_MS = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        touched,
	input  logic [11:0] raw_x,
	input  logic [11:0] raw_y,
	input  logic [11:0] raw_pressure,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [11:0] screen_x,
	output logic [11:0] screen_y,
	output logic [11:0] pressure,
	output logic        position_valid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tgd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tgd_dp #(
		.SAMPLES           (SAMPLES),
		.SWIPE_TIME_MIN_MS (SWIPE_TIME_MIN_MS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.touched        (touched),
		.raw_x          (raw_x),
		.raw_y          (raw_y),
		.raw_pressure   (raw_pressure),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.screen_x       (screen_x),
		.screen_y       (screen_y),
		.pressure       (pressure),
		.position_valid (position_valid)
	);

endmodule

// ===== hw/rtl/tgd_ctrl.sv =====
// Controller state machine of the touch gesture detector.
// Sequences mapping, division, averaging and event update. Depends on tgd_pkg.
module tgd_ctrl import tgd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_SETUP_X;
			S_SETUP_X: state_d = sts.touched ? S_DIV_X : S_RELEASE;
			S_DIV_X:   if (sts.div_last) state_d = S_SETUP_Y;
			S_SETUP_Y: state_d = S_DIV_Y;
			S_DIV_Y:   if (sts.div_last) state_d = S_GROUP;
			S_GROUP:   state_d = sts.grp_full ? S_AVG : S_IDLE;
			S_AVG:     if (sts.avg_last) state_d = S_PRESS;
			S_PRESS:   state_d = S_EMIT;
			S_RELEASE: state_d = S_EMIT;
			S_EMIT:    if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.in_load = in_valid;
			end
			S_SETUP_X: begin
				cmd.map_setup = 1'b1;
				cmd.map_sel = 1'b0;
			end
			S_DIV_X, S_DIV_Y: cmd.div_step = 1'b1;
			S_SETUP_Y: begin
				cmd.acc_x = 1'b1;
				cmd.map_setup = 1'b1;
				cmd.map_sel = 1'b1;
			end
			S_GROUP:   cmd.grp_upd = 1'b1;
			S_AVG:     cmd.avg_step = 1'b1;
			S_PRESS:   cmd.press = 1'b1;
			S_RELEASE: cmd.release_upd = 1'b1;
			S_EMIT:    cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/tgd_dp.sv =====
// Datapath of the touch gesture detector: config registers, shared range-mapping
// divider, group accumulators, reciprocal averaging, gesture state, output register.
// Depends on tgd_pkg.
module tgd_dp import tgd_pkg::*; #(
	parameter int SAMPLES           = 4,
	parameter int SWIPE_TIME_MIN_MS = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        touched,
	input  logic [11:0] raw_x,
	input  logic [11:0] raw_y,
	input  logic [11:0] raw_pressure,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [11:0] screen_x,
	output logic [11:0] screen_y,
	output logic [11:0] pressure,
	output logic        position_valid
);

	localparam int AVG_SHIFT = 16 + $clog2(SAMPLES);
	localparam logic [17:0] AVG_RECIP =
		18'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
	localparam logic [4:0] GRP_FULL = 5'(SAMPLES);
	localparam logic [31:0] TMIN = 32'(SWIPE_TIME_MIN_MS);

	// config
	logic [11:0] raw_x_min_q, raw_x_max_q, raw_y_min_q, raw_y_max_q;
	logic [11:0] scr_x_max_q, scr_y_max_q, swipe_dist_q;
	logic [15:0] swipe_tmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_x_min_q  <= 12'd200;
			raw_x_max_q  <= 12'd3800;
			raw_y_min_q  <= 12'd200;
			raw_y_max_q  <= 12'd3800;
			scr_x_max_q  <= 12'd319;
			scr_y_max_q  <= 12'd239;
			swipe_dist_q <= 12'd50;
			swipe_tmax_q <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RAW_X_MIN:    raw_x_min_q  <= cfg_data[11:0];
				REG_RAW_X_MAX:    raw_x_max_q  <= cfg_data[11:0];
				REG_RAW_Y_MIN:    raw_y_min_q  <= cfg_data[11:0];
				REG_RAW_Y_MAX:    raw_y_max_q  <= cfg_data[11:0];
				REG_SCREEN_X_MAX: scr_x_max_q  <= cfg_data[11:0];
				REG_SCREEN_Y_MAX: scr_y_max_q  <= cfg_data[11:0];
				REG_SWIPE_DIST:   swipe_dist_q <= cfg_data[11:0];
				REG_SWIPE_TMAX:   swipe_tmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input beat
	logic        touched_q;
	logic [11:0] rx_q, ry_q, rz_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			touched_q <= touched;
			rx_q      <= raw_x;
			ry_q      <= raw_y;
			rz_q      <= raw_pressure;
			now_q     <= now_ms;
		end
	end

	// range mapping setup: |v - lo| * smax over |hi - lo|
	logic [11:0] m_v, m_lo, m_hi, m_smax;
	logic [12:0] m_diff, m_den, m_adiff, m_aden;
	logic [23:0] m_prod;
	logic        m_zero;

	always_comb begin
		m_v    = cmd.map_sel ? rx_q : ry_q;
		m_lo   = cmd.map_sel ? raw_x_min_q : raw_y_min_q;
		m_hi   = cmd.map_sel ? raw_x_max_q : raw_y_max_q;
		m_smax = cmd.map_sel ? scr_y_max_q : scr_x_max_q;
		m_diff = {1'b0, m_v} - {1'b0, m_lo};
		m_den  = {1'b0, m_hi} - {1'b0, m_lo};
		m_adiff = m_diff[12] ? (13'd0 - m_diff) : m_diff;
		m_aden  = m_den[12] ? (13'd0 - m_den) : m_den;
		m_prod = m_adiff[11:0] * m_smax;
		m_zero = (m_den == 13'd0) || (m_prod == 24'd0) || (m_diff[12] != m_den[12]);
	end

	// restoring divider, one quotient bit per cycle
	logic [11:0] rem_q, dvs_q, smax_q;
	logic [23:0] quo_q;
	logic        zero_q;
	logic [4:0]  cnt_q;
	logic [12:0] trial;
	logic        fits;
	logic [11:0] mapped;

	assign trial  = {rem_q, quo_q[23]};
	assign fits   = trial >= {1'b0, dvs_q};
	assign mapped = zero_q ? 12'd0 :
		((quo_q > {12'd0, smax_q}) ? smax_q : quo_q[11:0]);

	always_ff @(posedge clk) begin
		if (cmd.map_setup) begin
			rem_q  <= '0;
			quo_q  <= m_prod;
			dvs_q  <= m_aden[11:0];
			smax_q <= m_smax;
			zero_q <= m_zero;
		end else if (cmd.div_step) begin
			rem_q <= fits ? 12'(trial - {1'b0, dvs_q}) : trial[11:0];
			quo_q <= {quo_q[22:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.map_setup || cmd.grp_upd) begin
			cnt_q <= '0;
		end else if (cmd.div_step || cmd.avg_step) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// group accumulation and averaging
	logic [4:0]  grp_cnt_q, grp_cnt_nxt;
	logic [15:0] sum_x_q, sum_y_q, sum_z_q, avg_src;
	logic [33:0] avg_prod, avg_sh;
	logic [11:0] cur_x_q, cur_y_q, cur_z_q;
	logic        cur_valid_q;

	assign grp_cnt_nxt = grp_cnt_q + 5'd1;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    avg_src = sum_x_q;
			2'd1:    avg_src = sum_y_q;
			default: avg_src = sum_z_q;
		endcase
		avg_prod = avg_src * AVG_RECIP;
		avg_sh   = avg_prod >> AVG_SHIFT;
	end

	// gesture state
	kind_t       kind_q, kind_rel;
	logic [11:0] start_x_q, start_y_q;
	logic [31:0] start_t_q, dt;
	logic        start_valid_q;
	logic [12:0] dx, dy, adx, ady;

	always_comb begin
		dx  = {1'b0, start_x_q} - {1'b0, cur_x_q};
		dy  = {1'b0, start_y_q} - {1'b0, cur_y_q};
		adx = dx[12] ? (13'd0 - dx) : dx;
		ady = dy[12] ? (13'd0 - dy) : dy;
		dt  = now_q - start_t_q;
		kind_rel = EV_UP;
		if ((kind_q == EV_DOWN || kind_q == EV_HOLD) && start_valid_q &&
			dt > TMIN && dt < {16'd0, swipe_tmax_q}) begin
			if (adx > {1'b0, swipe_dist_q}) begin
				kind_rel = dx[12] ? EV_SWIPE_RIGHT : EV_SWIPE_LEFT;
			end else if (ady > {1'b0, swipe_dist_q}) begin
				kind_rel = dy[12] ? EV_SWIPE_DOWN : EV_SWIPE_UP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_cnt_q     <= '0;
			sum_x_q       <= '0;
			sum_y_q       <= '0;
			sum_z_q       <= '0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			cur_z_q       <= '0;
			cur_valid_q   <= 1'b0;
			kind_q        <= EV_UP;
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_t_q     <= '0;
			start_valid_q <= 1'b0;
		end else begin
			if (cmd.acc_x) sum_x_q <= sum_x_q + {4'd0, mapped};
			if (cmd.grp_upd) begin
				sum_y_q   <= sum_y_q + {4'd0, mapped};
				sum_z_q   <= sum_z_q + {4'd0, rz_q};
				grp_cnt_q <= grp_cnt_nxt;
			end
			if (cmd.avg_step) begin
				case (cnt_q[1:0])
					2'd0:    cur_x_q <= avg_sh[11:0];
					2'd1:    cur_y_q <= avg_sh[11:0];
					default: cur_z_q <= avg_sh[11:0];
				endcase
			end
			if (cmd.press || cmd.release_upd) begin
				grp_cnt_q <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				sum_z_q   <= '0;
			end
			if (cmd.press) begin
				cur_valid_q <= 1'b1;
				if (kind_q == EV_DOWN || kind_q == EV_HOLD) begin
					kind_q <= EV_HOLD;
				end else begin
					kind_q <= EV_DOWN;
					// a start is recorded only by a press that follows up
					if (kind_q == EV_UP) begin
						start_x_q     <= cur_x_q;
						start_y_q     <= cur_y_q;
						start_t_q     <= now_q;
						start_valid_q <= 1'b1;
					end
				end
			end
			if (cmd.release_upd) begin
				kind_q        <= kind_rel;
				start_x_q     <= '0;
				start_y_q     <= '0;
				start_t_q     <= '0;
				start_valid_q <= 1'b0;
			end
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			event_kind     <= kind_q;
			screen_x       <= cur_x_q;
			screen_y       <= cur_y_q;
			pressure       <= cur_z_q;
			position_valid <= cur_valid_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.touched  = touched_q;
	assign sts.div_last = (cnt_q == 5'(DIV_STEPS - 1));
	assign sts.grp_full = (grp_cnt_nxt == GRP_FULL);
	assign sts.avg_last = (cnt_q[1:0] == 2'd2);
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

// ===== hw/rtl/tgd_checker.sv =====
// Port-level checks for the touch gesture detector, bound to the top level.
// Depends on tgd_pkg.
module tgd_checker import tgd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_kind,
	input logic       position_valid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind))
		else $error("result beat dropped under stall");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind != 3'd7)
		else $error("undefined event code");

	a_press_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_DOWN || event_kind == EV_HOLD) |-> position_valid)
		else $error("press without valid position");

	a_no_gesture_before_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !position_valid |-> event_kind == EV_UP)
		else $error("gesture reported before any press");

endmodule

bind touch_gesture_detector tgd_checker u_tgd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.event_kind     (event_kind),
	.position_valid (position_valid)
);

// ===== dv/touch_gesture_detector_tb.sv =====
// Testbench for touch_gesture_detector: directed stimulus table, then random gestures.
// Results are checked against an in-bench gesture predictor. Depends on tgd_pkg and the RTL.
`timescale 1ns / 100ps

module touch_gesture_detector_tb;
	import tgd_pkg::*;

	localparam int SAMPLES      = 4;
	localparam int SWIPE_MIN_MS = 50;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		bit        touched;
		bit [11:0] rx;
		bit [11:0] ry;
		bit [11:0] rz;
		bit [31:0] now;
	} sample_t;

	typedef struct {
		kind_t     kind;
		bit [11:0] x;
		bit [11:0] y;
		bit [11:0] z;
		bit        pv;
	} event_t;

	// directed row: sample repeated reps times; typed result checked on the last one
	typedef struct {
		sample_t s;
		int      reps;
		bit      typed;
		event_t  ev;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        touched;
	logic [11:0] raw_x;
	logic [11:0] raw_y;
	logic [11:0] raw_pressure;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [11:0] screen_x;
	logic [11:0] screen_y;
	logic [11:0] pressure;
	logic        position_valid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	touch_gesture_detector #(.SAMPLES(SAMPLES), .SWIPE_TIME_MIN_MS(SWIPE_MIN_MS)) uut (.*);

	// predictor state
	bit [15:0] regs [8];
	int        grp_cnt;
	bit [15:0] acc_x, acc_y, acc_z;
	kind_t     cur_kind;
	bit [11:0] cur_x, cur_y, cur_z;
	bit        cur_valid;
	bit [11:0] start_x, start_y;
	bit [31:0] start_ms;
	bit        start_valid;

	event_t    pending_events [$];
	int        errors;
	int        items;
	int        n_events;
	int        n_swipes;
	int        idle_cnt;
	int        stall_left;
	bit        quiet;
	bit [31:0] clock_ms;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	function automatic bit [11:0] map_axis(bit [11:0] v, bit [11:0] lo, bit [11:0] hi,
			bit [11:0] smax);
		longint num, den, q;
		num = (longint'(v) - longint'(lo)) * longint'(smax);
		den = longint'(hi) - longint'(lo);
		if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
			return 12'd0;
		if (num < 0) num = -num;
		if (den < 0) den = -den;
		q = num / den;
		return (q > smax) ? smax : q[11:0];
	endfunction

	function automatic void reset_gestures();
		regs = '{16'd200, 16'd3800, 16'd200, 16'd3800, 16'd319, 16'd239, 16'd50, 16'd1000};
		grp_cnt = 0; acc_x = 0; acc_y = 0; acc_z = 0;
		cur_kind = EV_UP; cur_x = 0; cur_y = 0; cur_z = 0; cur_valid = 0;
		start_x = 0; start_y = 0; start_ms = 0; start_valid = 0;
	endfunction

	// returns 1 when the sample produces an event
	function automatic bit gesture_step(sample_t s, output event_t ev);
		kind_t     prev;
		int        dx, dy, adx, ady;
		bit [31:0] dt;
		prev = cur_kind;
		if (s.touched) begin
			acc_x = acc_x + {4'd0, map_axis(s.ry, regs[REG_RAW_Y_MIN][11:0],
				regs[REG_RAW_Y_MAX][11:0], regs[REG_SCREEN_X_MAX][11:0])};
			acc_y = acc_y + {4'd0, map_axis(s.rx, regs[REG_RAW_X_MIN][11:0],
				regs[REG_RAW_X_MAX][11:0], regs[REG_SCREEN_Y_MAX][11:0])};
			acc_z = acc_z + {4'd0, s.rz};
			grp_cnt++;
			if (grp_cnt < SAMPLES)
				return 0;
			cur_x = 12'(acc_x / SAMPLES);
			cur_y = 12'(acc_y / SAMPLES);
			cur_z = 12'(acc_z / SAMPLES);
			cur_valid = 1;
			grp_cnt = 0; acc_x = 0; acc_y = 0; acc_z = 0;
			if (prev == EV_DOWN || prev == EV_HOLD) begin
				cur_kind = EV_HOLD;
			end else begin
				cur_kind = EV_DOWN;
				// start recorded only when coming from up, not after a swipe
				if (prev == EV_UP) begin
					start_x = cur_x; start_y = cur_y; start_ms = s.now; start_valid = 1;
				end
			end
		end else begin
			grp_cnt = 0; acc_x = 0; acc_y = 0; acc_z = 0;
			cur_kind = EV_UP;
			if ((prev == EV_DOWN || prev == EV_HOLD) && start_valid) begin
				dx = int'(start_x) - int'(cur_x);
				dy = int'(start_y) - int'(cur_y);
				adx = dx < 0 ? -dx : dx;
				ady = dy < 0 ? -dy : dy;
				dt = s.now - start_ms;
				if (dt > SWIPE_MIN_MS && dt < regs[REG_SWIPE_TMAX]) begin
					if (adx > regs[REG_SWIPE_DIST][11:0])
						cur_kind = dx < 0 ? EV_SWIPE_RIGHT : EV_SWIPE_LEFT;
					else if (ady > regs[REG_SWIPE_DIST][11:0])
						cur_kind = dy < 0 ? EV_SWIPE_DOWN : EV_SWIPE_UP;
				end
			end
			start_x = 0; start_y = 0; start_ms = 0; start_valid = 0;
		end
		ev = '{cur_kind, cur_x, cur_y, cur_z, cur_valid};
		return 1;
	endfunction

	task automatic send_sample(sample_t s, bit typed, event_t typed_ev);
		int     gap;
		event_t ev;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		touched      <= s.touched;
		raw_x        <= s.rx;
		raw_y        <= s.ry;
		raw_pressure <= s.rz;
		now_ms       <= s.now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items++;
		if (gesture_step(s, ev))
			pending_events.push_back(typed ? typed_ev : ev);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		// a touched sample that completes no group may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(bit [15:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			regs[i] = (i == REG_SWIPE_TMAX) ? vals[i] : {4'd0, vals[i][11:0]};
		end
		cfg_valid <= 1'b0;
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_events++;
			if (pending_events.size() == 0) begin
				$display("mismatch: event beat with nothing pending (t=%0t)", $time);
				errors++;
			end else begin
				event_t want;
				want = pending_events.pop_front();
				if (event_kind != want.kind) report("event_kind", event_kind, want.kind);
				if (screen_x != want.x) report("screen_x", screen_x, want.x);
				if (screen_y != want.y) report("screen_y", screen_y, want.y);
				if (pressure != want.z) report("pressure", pressure, want.z);
				if (position_valid != want.pv) report("position_valid", position_valid, want.pv);
				if (want.kind >= EV_SWIPE_LEFT) n_swipes++;
			end
			stall_left = quiet ? 0 : $urandom_range(0, 4);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("status: fail");
			$finish;
		end
	end

	task automatic random_gesture();
		sample_t   s;
		int        presses, tail;
		bit [11:0] bx, by;
		if ($urandom_range(0, 99) < 15) begin
			s = '{1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom), 12'($urandom),
				$urandom};
			send_sample(s, 0, '{EV_UP, 0, 0, 0, 0});
			return;
		end
		if ($urandom_range(0, 19) == 0)
			clock_ms = $urandom;
		bx = 12'($urandom);
		by = 12'($urandom);
		presses = $urandom_range(1, 4);
		for (int p = 0; p < presses; p++) begin
			// drag the finger between presses so swipes show up
			if ($urandom_range(0, 1)) bx = 12'($urandom);
			if ($urandom_range(0, 1)) by = 12'($urandom);
			for (int k = 0; k < SAMPLES; k++) begin
				clock_ms += $urandom_range(0, 40);
				s = '{1'b1, bx ^ 12'($urandom_range(0, 15)), by ^ 12'($urandom_range(0, 15)),
					12'($urandom), clock_ms};
				send_sample(s, 0, '{EV_UP, 0, 0, 0, 0});
			end
		end
		tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, SAMPLES - 1) : 0;
		for (int k = 0; k < tail; k++) begin
			clock_ms += $urandom_range(0, 40);
			s = '{1'b1, 12'($urandom), 12'($urandom), 12'($urandom), clock_ms};
			send_sample(s, 0, '{EV_UP, 0, 0, 0, 0});
		end
		clock_ms += $urandom_range(0, 600);
		s = '{1'b0, 12'($urandom), 12'($urandom), 12'($urandom), clock_ms};
		send_sample(s, 0, '{EV_UP, 0, 0, 0, 0});
	endtask

	row_t      dir_rows [$];
	bit [15:0] phase_regs [6][8];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; touched = 1'b0; raw_x = '0; raw_y = '0; raw_pressure = '0;
		now_ms = '0; out_stall = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		errors = 0; items = 0; n_events = 0; n_swipes = 0; idle_cnt = 0; stall_left = 0;
		quiet = 0; clock_ms = 0;
		reset_gestures();

		dir_rows = '{
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd0}, 1, 1, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd200, 12'd200, 12'd0, 32'd100}, 4, 1, '{EV_DOWN, 0, 0, 0, 1}},
			'{'{1, 12'd4095, 12'd4095, 12'd4095, 32'd400}, 4, 1,
				'{EV_HOLD, 319, 239, 4095, 1}},
			'{'{0, 12'd4095, 12'd4095, 12'd4095, 32'd500}, 1, 1,
				'{EV_SWIPE_RIGHT, 319, 239, 4095, 1}},
			// press after a swipe: down without a start, then plain up
			'{'{1, 12'd0, 12'd4095, 12'd100, 32'd1000}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd1100}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			// swipe left
			'{'{1, 12'd2000, 12'd4095, 12'd5, 32'd2000}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd2000, 12'd200, 12'd5, 32'd2100}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd2200}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd2300}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			// swipe down, then swipe up
			'{'{1, 12'd200, 12'd2000, 12'd7, 32'd3000}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd4095, 12'd2000, 12'd7, 32'd3100}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd3200}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd3300}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd4095, 12'd2000, 12'd7, 32'd4000}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd200, 12'd2000, 12'd7, 32'd4100}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd4200}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			// too fast, then across the time wrap
			'{'{1, 12'd200, 12'd200, 12'd9, 32'd5000}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd4095, 12'd4095, 12'd9, 32'd5010}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd5020}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd200, 12'd200, 12'd9, 32'hFFFF_FF00}, 4, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{1, 12'd4095, 12'd4095, 12'd9, 32'hFFFF_FF00}, 8, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd100}, 1, 0, '{EV_UP, 0, 0, 0, 0}},
			// partial group discarded by a release
			'{'{1, 12'd1234, 12'd3210, 12'd77, 32'd200}, 3, 0, '{EV_UP, 0, 0, 0, 0}},
			'{'{0, 12'd0, 12'd0, 12'd0, 32'd90000}, 1, 0, '{EV_UP, 0, 0, 0, 0}}
		};

		phase_regs[0] = '{16'd0, 16'd4095, 16'd0, 16'd4095, 16'd4095, 16'd4095, 16'd0, 16'd65535};
		phase_regs[1] = '{16'd4095, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd0};
		phase_regs[2] = '{16'd1000, 16'd1000, 16'd2000, 16'd2000, 16'd100, 16'd100, 16'd10,
			16'd300};
		phase_regs[3] = '{16'd3800, 16'd200, 16'd200, 16'd3800, 16'd799, 16'd479, 16'd30,
			16'd1500};
		phase_regs[4] = '{16'd500, 16'd3500, 16'd300, 16'd3700, 16'd479, 16'd319, 16'd20,
			16'd2000};
		phase_regs[5] = '{16'd200, 16'd3800, 16'd200, 16'd3800, 16'd319, 16'd239, 16'd50,
			16'd1000};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			for (int r = 0; r < dir_rows[i].reps; r++)
				send_sample(dir_rows[i].s, dir_rows[i].typed && r == dir_rows[i].reps - 1,
					dir_rows[i].ev);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			bit [15:0] vals [8];
			if (ph < 6) begin
				vals = phase_regs[ph];
			end else begin
				foreach (vals[k]) vals[k] = 16'($urandom);
			end
			quiet = (ph == 4);
			write_regs(vals);
			while (items < 80 + (ph + 1) * 270)
				random_gesture();
			drain();
		end

		$display("covered %0d samples, %0d events (%0d swipes) over 7 register settings",
			items, n_events, n_swipes);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
